[design/irtl_pkg.sv]
// Shared types and constants for the IP range table lookup unit.
package irtl_pkg;

  localparam int DEFAULT_TABLE_DEPTH = 1024;
  localparam int ADDR_W = 32;
  localparam int REGION_W = 16;
  localparam int STATUS_W = 2;
  localparam int IDX_OUT_W = 10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2,
    STATUS_BELOW = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_FIN_EMPTY,
    S_FIN_FULL,
    S_FIN_LOOKUP,
    S_FIN_INSERT
  } ctrl_state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_SRCH_RD,
    DP_SRCH_CMP,
    DP_RES_RD,
    DP_SHIFT_INIT,
    DP_SHIFT_RD,
    DP_SHIFT_WR,
    DP_INS_WR,
    DP_LOAD_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    OUT_EMPTY,
    OUT_FULL,
    OUT_LOOKUP,
    OUT_INSERT
  } out_sel_t;

  typedef struct packed {
    dp_op_t   op;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_lookup;
    logic table_empty;
    logic table_full;
    logic search_done;
    logic shift_done;
    logic out_free;
  } dp_status_t;

endpackage

[design/irtl_ctrl.sv]
// Sequencing state machine for the IP range table lookup unit.
module irtl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  irtl_pkg::dp_status_t dp_status,
  output irtl_pkg::dp_cmd_t   dp_cmd
);

  irtl_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= irtl_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    dp_cmd.op      = irtl_pkg::DP_NOP;
    dp_cmd.out_sel = irtl_pkg::OUT_INSERT;
    // no beat is taken while reset is held
    in_stall       = rst || (state != irtl_pkg::S_IDLE);
    unique case (state)
      irtl_pkg::S_IDLE: begin
        if (in_valid && !in_stall) begin
          dp_cmd.op  = irtl_pkg::DP_CAPTURE;
          state_next = irtl_pkg::S_DECIDE;
        end
      end
      irtl_pkg::S_DECIDE: begin
        priority if (dp_status.is_lookup && dp_status.table_empty) begin
          state_next = irtl_pkg::S_FIN_EMPTY;
        end else if (!dp_status.is_lookup && dp_status.table_full) begin
          state_next = irtl_pkg::S_FIN_FULL;
        end else begin
          state_next = irtl_pkg::S_SRCH_RD;
        end
      end
      irtl_pkg::S_SRCH_RD: begin
        priority if (!dp_status.search_done) begin
          dp_cmd.op  = irtl_pkg::DP_SRCH_RD;
          state_next = irtl_pkg::S_SRCH_CMP;
        end else if (dp_status.is_lookup) begin
          dp_cmd.op  = irtl_pkg::DP_RES_RD;
          state_next = irtl_pkg::S_FIN_LOOKUP;
        end else begin
          dp_cmd.op  = irtl_pkg::DP_SHIFT_INIT;
          state_next = irtl_pkg::S_SHIFT_RD;
        end
      end
      irtl_pkg::S_SRCH_CMP: begin
        dp_cmd.op  = irtl_pkg::DP_SRCH_CMP;
        state_next = irtl_pkg::S_SRCH_RD;
      end
      irtl_pkg::S_SHIFT_RD: begin
        if (dp_status.shift_done) begin
          dp_cmd.op  = irtl_pkg::DP_INS_WR;
          state_next = irtl_pkg::S_FIN_INSERT;
        end else begin
          dp_cmd.op  = irtl_pkg::DP_SHIFT_RD;
          state_next = irtl_pkg::S_SHIFT_WR;
        end
      end
      irtl_pkg::S_SHIFT_WR: begin
        dp_cmd.op  = irtl_pkg::DP_SHIFT_WR;
        state_next = irtl_pkg::S_SHIFT_RD;
      end
      irtl_pkg::S_FIN_EMPTY: begin
        dp_cmd.out_sel = irtl_pkg::OUT_EMPTY;
        if (dp_status.out_free) begin
          dp_cmd.op  = irtl_pkg::DP_LOAD_OUT;
          state_next = irtl_pkg::S_IDLE;
        end
      end
      irtl_pkg::S_FIN_FULL: begin
        dp_cmd.out_sel = irtl_pkg::OUT_FULL;
        if (dp_status.out_free) begin
          dp_cmd.op  = irtl_pkg::DP_LOAD_OUT;
          state_next = irtl_pkg::S_IDLE;
        end
      end
      irtl_pkg::S_FIN_LOOKUP: begin
        dp_cmd.out_sel = irtl_pkg::OUT_LOOKUP;
        if (dp_status.out_free) begin
          dp_cmd.op  = irtl_pkg::DP_LOAD_OUT;
          state_next = irtl_pkg::S_IDLE;
        end
      end
      irtl_pkg::S_FIN_INSERT: begin
        dp_cmd.out_sel = irtl_pkg::OUT_INSERT;
        if (dp_status.out_free) begin
          dp_cmd.op  = irtl_pkg::DP_LOAD_OUT;
          state_next = irtl_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = irtl_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[design/irtl_datapath.sv]
// Table memories, search bounds, shift counter and output register.
module irtl_datapath #(
  parameter int TABLE_DEPTH = irtl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  irtl_pkg::dp_cmd_t             dp_cmd,
  output irtl_pkg::dp_status_t          dp_status,
  input  logic                          opcode,
  input  logic [irtl_pkg::ADDR_W-1:0]   address,
  input  logic [irtl_pkg::REGION_W-1:0] region_id,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          kind,
  output logic [irtl_pkg::STATUS_W-1:0] status,
  output logic [irtl_pkg::REGION_W-1:0] found_region,
  output logic [irtl_pkg::IDX_OUT_W-1:0] found_index
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int OW    = irtl_pkg::IDX_OUT_W;

  logic [irtl_pkg::ADDR_W-1:0]   start_mem  [TABLE_DEPTH];
  logic [irtl_pkg::REGION_W-1:0] region_mem [TABLE_DEPTH];

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] lo, hi, mid_q, shift_idx;
  logic             item_op;
  logic [irtl_pkg::ADDR_W-1:0]   item_addr;
  logic [irtl_pkg::REGION_W-1:0] item_region;
  logic [irtl_pkg::ADDR_W-1:0]   rd_start;
  logic [irtl_pkg::REGION_W-1:0] rd_region;

  logic [CNT_W-1:0] mid;
  logic [CNT_W-1:0] lo_dec;
  logic [CNT_W-1:0] rd_ptr;
  logic [CNT_W-1:0] wr_ptr;
  logic             rd_en, wr_en;
  logic [irtl_pkg::ADDR_W-1:0]   wr_start;
  logic [irtl_pkg::REGION_W-1:0] wr_region;
  logic [CNT_W-1:0] res_idx;
  logic [CNT_W+OW-1:0] idx_ext;

  assign mid    = lo + ((hi - lo) >> 1);
  assign lo_dec = lo - CNT_W'(1);

  assign dp_status.is_lookup   = (item_op == irtl_pkg::OP_LOOKUP);
  assign dp_status.table_empty = (entry_count == '0);
  assign dp_status.table_full  = (entry_count >= CNT_W'(TABLE_DEPTH));
  assign dp_status.search_done = (lo >= hi);
  assign dp_status.shift_done  = (shift_idx <= lo);
  assign dp_status.out_free    = !out_valid || !out_stall;

  // Memory port selection
  always_comb begin
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    rd_ptr    = mid;
    wr_ptr    = shift_idx;
    wr_start  = rd_start;
    wr_region = rd_region;
    unique case (dp_cmd.op)
      irtl_pkg::DP_SRCH_RD: begin
        rd_en  = 1'b1;
        rd_ptr = mid;
      end
      irtl_pkg::DP_RES_RD: begin
        rd_en  = 1'b1;
        rd_ptr = (lo == '0) ? '0 : lo_dec;
      end
      irtl_pkg::DP_SHIFT_RD: begin
        rd_en  = 1'b1;
        rd_ptr = shift_idx - CNT_W'(1);
      end
      irtl_pkg::DP_SHIFT_WR: begin
        wr_en  = 1'b1;
        wr_ptr = shift_idx;
      end
      irtl_pkg::DP_INS_WR: begin
        wr_en     = 1'b1;
        wr_ptr    = lo;
        wr_start  = item_addr;
        wr_region = item_region;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      start_mem[wr_ptr[IDX_W-1:0]]  <= wr_start;
      region_mem[wr_ptr[IDX_W-1:0]] <= wr_region;
    end
    if (rd_en) begin
      rd_start  <= start_mem[rd_ptr[IDX_W-1:0]];
      rd_region <= region_mem[rd_ptr[IDX_W-1:0]];
    end
  end

  // Item capture, search bounds, shift counter, entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      lo          <= '0;
      hi          <= '0;
    end else begin
      unique case (dp_cmd.op)
        irtl_pkg::DP_CAPTURE: begin
          lo <= '0;
          hi <= entry_count;
        end
        irtl_pkg::DP_SRCH_CMP: begin
          if (rd_start <= item_addr) begin
            lo <= mid_q + CNT_W'(1);
          end else begin
            hi <= mid_q;
          end
        end
        irtl_pkg::DP_INS_WR: begin
          entry_count <= entry_count + CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (dp_cmd.op)
      irtl_pkg::DP_CAPTURE: begin
        item_op     <= opcode;
        item_addr   <= address;
        item_region <= region_id;
      end
      irtl_pkg::DP_SRCH_RD:    mid_q     <= mid;
      irtl_pkg::DP_SHIFT_INIT: shift_idx <= entry_count;
      irtl_pkg::DP_SHIFT_WR:   shift_idx <= shift_idx - CNT_W'(1);
      default: begin
      end
    endcase
  end

  // Output register
  assign res_idx = (lo == '0) ? '0 : lo_dec;
  assign idx_ext = {{OW{1'b0}}, (dp_cmd.out_sel == irtl_pkg::OUT_LOOKUP) ? res_idx : lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (dp_cmd.op == irtl_pkg::DP_LOAD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.op == irtl_pkg::DP_LOAD_OUT) begin
      kind <= item_op;
      unique case (dp_cmd.out_sel)
        irtl_pkg::OUT_EMPTY: begin
          status       <= irtl_pkg::STATUS_EMPTY;
          found_region <= '0;
          found_index  <= '0;
        end
        irtl_pkg::OUT_FULL: begin
          status       <= irtl_pkg::STATUS_FULL;
          found_region <= '0;
          found_index  <= '0;
        end
        irtl_pkg::OUT_LOOKUP: begin
          status       <= (lo == '0) ? irtl_pkg::STATUS_BELOW : irtl_pkg::STATUS_OK;
          found_region <= rd_region;
          found_index  <= idx_ext[OW-1:0];
        end
        irtl_pkg::OUT_INSERT: begin
          status       <= irtl_pkg::STATUS_OK;
          found_region <= '0;
          found_index  <= idx_ext[OW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == irtl_pkg::DP_LOAD_OUT) |-> (!out_valid || !out_stall))
    else $error("result loaded over an undelivered beat");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == irtl_pkg::DP_INS_WR) |-> !dp_status.table_full)
    else $error("insert write into a full table");

  a_bounds_order: assert property (@(posedge clk) disable iff (rst)
    lo <= hi)
    else $error("search bounds crossed");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.op == irtl_pkg::DP_LOAD_OUT) |=> out_valid)
    else $error("loaded result not presented");

endmodule

[design/ip_range_table_lookup_unit.sv]
// IP range table lookup unit: sorted IPv4 range-start table with binary-search lookup.
//
// The unit holds up to TABLE_DEPTH entries (range start, region id) sorted
// ascending by start. Each input beat yields exactly one result beat. An insert
// (opcode 0) binary-searches for the first entry whose start is above the new
// address, shifts that entry and every entry above it up by one and writes the new entry there,
// so equal starts keep arrival order and a lookup returns the newest of them;
// the result carries the new position, or status 1 if the table is full. A
// lookup (opcode 1) returns the region id and position of the last entry whose
// start is at or below the address; an empty table gives status 2, and an
// address below every start returns entry 0 with status 3. One item is worked
// at a time. Each search iteration has a read step and a compare step, because
// the table memories have a single registered read port. An insert also shifts
// every entry at or above the insertion point up by one, and each shifted entry
// needs one memory read and one memory write. Empty and full cases skip the
// search. A finished result sits in an output register, so the next beat is
// accepted while it waits. in_stall stays high while rst is held. Table
// contents are not cleared at reset; only the entry count is, and no entry at
// or above it is ever read.
module ip_range_table_lookup_unit #(
  parameter int TABLE_DEPTH = irtl_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [irtl_pkg::ADDR_W-1:0]    address,
  input  logic [irtl_pkg::REGION_W-1:0]  region_id,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           kind,
  output logic [irtl_pkg::STATUS_W-1:0]  status,
  output logic [irtl_pkg::REGION_W-1:0]  found_region,
  output logic [irtl_pkg::IDX_OUT_W-1:0] found_index
);

  irtl_pkg::dp_cmd_t    dp_cmd;
  irtl_pkg::dp_status_t dp_status;

  // Sequencer: capture, search iterations, shift loop, result hand-off
  irtl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .dp_status (dp_status),
    .dp_cmd    (dp_cmd)
  );

  // Table memories, bounds and the result register
  irtl_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .dp_cmd       (dp_cmd),
    .dp_status    (dp_status),
    .opcode       (opcode),
    .address      (address),
    .region_id    (region_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .status       (status),
    .found_region (found_region),
    .found_index  (found_index)
  );

endmodule
